// File: sv/rclp_pkg.sv
package rclp_pkg;

    localparam int NAME_MAX    = 9;
    localparam int CMD_COUNT   = 20;
    localparam int QUEUE_DEPTH = 2;

    // input kinds
    localparam logic KIND_BYTE = 1'b0;
    localparam logic KIND_END  = 1'b1;

    // result kinds
    localparam logic RK_ARG     = 1'b0;
    localparam logic RK_SUMMARY = 1'b1;

    // command codes
    localparam logic [4:0] OP_NONE      = 5'd0;
    localparam logic [4:0] OP_PING      = 5'd1;
    localparam logic [4:0] OP_SET       = 5'd2;
    localparam logic [4:0] OP_GET       = 5'd3;
    localparam logic [4:0] OP_DEL       = 5'd4;
    localparam logic [4:0] OP_EXISTS    = 5'd5;
    localparam logic [4:0] OP_APPEND    = 5'd6;
    localparam logic [4:0] OP_RANDOMKEY = 5'd7;
    localparam logic [4:0] OP_EXPIRE    = 5'd8;
    localparam logic [4:0] OP_PEXPIRE   = 5'd9;
    localparam logic [4:0] OP_PERSIST   = 5'd10;
    localparam logic [4:0] OP_TTL       = 5'd11;
    localparam logic [4:0] OP_KEYS      = 5'd12;
    localparam logic [4:0] OP_PTTL      = 5'd13;
    localparam logic [4:0] OP_RENAME    = 5'd14;
    localparam logic [4:0] OP_COPY      = 5'd15;
    localparam logic [4:0] OP_INCR      = 5'd16;
    localparam logic [4:0] OP_DECR      = 5'd17;
    localparam logic [4:0] OP_INCRBY    = 5'd18;
    localparam logic [4:0] OP_DECRBY    = 5'd19;
    localparam logic [4:0] OP_HELPER    = 5'd20;
    localparam logic [4:0] OP_UNKNOWN   = 5'd21;

    // line classes
    localparam logic [1:0] LC_IDLE    = 2'd0;
    localparam logic [1:0] LC_STAR    = 2'd1;
    localparam logic [1:0] LC_DOLLAR  = 2'd2;
    localparam logic [1:0] LC_CONTENT = 2'd3;

    // argument slots
    localparam logic [1:0] SLOT_ARG   = 2'd0;
    localparam logic [1:0] SLOT_KEY   = 2'd1;
    localparam logic [1:0] SLOT_VALUE = 2'd2;
    localparam logic [1:0] SLOT_MULTI = 2'd3;

    // star number phases
    localparam logic [1:0] PH_BLANK  = 2'd0;
    localparam logic [1:0] PH_SIGN   = 2'd1;
    localparam logic [1:0] PH_DIGITS = 2'd2;
    localparam logic [1:0] PH_STOP   = 2'd3;

    // content line counter saturates here, only 1, 2 and 3 matter
    localparam logic [2:0] CNT_SAT = 3'd4;

    localparam logic [31:0] MAG_CAP = 32'h8000_0000;
    localparam logic [31:0] POS_MAX = 32'h7FFF_FFFF;

    localparam logic [71:0] CMD_NAME [CMD_COUNT] = '{
        "PING", "SET", "GET", "DEL", "EXISTS", "APPEND", "RANDOMKEY", "EXPIRE",
        "PEXPIRE", "PERSIST", "TTL", "KEYS", "PTTL", "RENAME", "COPY", "INCR",
        "DECR", "INCRBY", "DECRBY", "HELPER"
    };

    localparam logic [3:0] CMD_LEN [CMD_COUNT] = '{
        4'd4, 4'd3, 4'd3, 4'd3, 4'd6, 4'd6, 4'd9, 4'd6, 4'd7, 4'd7,
        4'd3, 4'd4, 4'd4, 4'd6, 4'd4, 4'd4, 4'd4, 4'd6, 4'd6, 4'd6
    };

    // character p of name i, zero past its end while p is below NAME_MAX
    function automatic logic [7:0] name_char(input int i, input logic [3:0] p);
        logic [71:0] w;
        int          idx;
        w   = CMD_NAME[i] << (8 * (NAME_MAX - int'(CMD_LEN[i])));
        idx = (p < 4'(NAME_MAX)) ? int'(p) : 0;
        return w[71 - 8 * idx -: 8];
    endfunction

    typedef struct packed {
        logic       kind;
        logic [7:0] data;
        logic       is_eol;
        logic       is_star;
        logic       is_dollar;
        logic       is_digit;
        logic       is_blank;
        logic       is_sign;
        logic       is_minus;
    } t_item;

    typedef struct packed {
        logic        result_kind;
        logic [4:0]  command;
        logic [1:0]  slot;
        logic [2:0]  key_number;
        logic [7:0]  offset;
        logic [7:0]  arg_byte;
        logic [31:0] key_count;
    } t_result;

endpackage

// File: sv/rclp_in_if.sv
interface rclp_in_if;
    logic       valid;
    logic       ready;
    logic       kind;
    logic [7:0] data_byte;

    modport source (output valid, output kind, output data_byte, input ready);
    modport sink (input valid, input kind, input data_byte, output ready);
endinterface

// File: sv/rclp_out_if.sv
interface rclp_out_if;
    logic               valid;
    logic               ready;
    logic               result_kind;
    logic [4:0]         command;
    logic [1:0]         slot;
    logic [2:0]         key_number;
    logic [7:0]         offset;
    logic [7:0]         arg_byte;
    logic signed [31:0] key_count;

    modport source (
        output valid, output result_kind, output command, output slot,
        output key_number, output offset, output arg_byte, output key_count,
        input ready
    );
    modport sink (
        input valid, input result_kind, input command, input slot,
        input key_number, input offset, input arg_byte, input key_count,
        output ready
    );
endinterface

// File: sv/rclp_front.sv
module rclp_front (
    rclp_in_if.sink        i_cmd,
    input  logic           i_full,
    output logic           o_push,
    output rclp_pkg::t_item o_item
);
    import rclp_pkg::*;

    logic [7:0] b;

    assign b          = i_cmd.data_byte;
    assign i_cmd.ready = !i_full;
    assign o_push     = i_cmd.valid && !i_full;

    always_comb begin
        o_item.kind      = i_cmd.kind;
        o_item.data      = b;
        o_item.is_eol    = (b == 8'h0D) || (b == 8'h0A);
        o_item.is_star   = (b == 8'h2A);
        o_item.is_dollar = (b == 8'h24);
        o_item.is_digit  = (b >= 8'h30) && (b <= 8'h39);
        // space, tab, vertical tab, form feed
        o_item.is_blank  = (b == 8'h20) || (b == 8'h09) || (b == 8'h0B) || (b == 8'h0C);
        o_item.is_sign   = (b == 8'h2B) || (b == 8'h2D);
        o_item.is_minus  = (b == 8'h2D);
    end
endmodule

// File: sv/rclp_queue.sv
module rclp_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  rclp_pkg::t_item i_item,
    output logic            o_full,
    output logic            o_valid,
    output rclp_pkg::t_item o_item,
    input  logic            i_pop
);
    import rclp_pkg::*;

    localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    t_item          r_mem [QUEUE_DEPTH];
    logic [PW-1:0]  r_wr_ptr, n_wr_ptr;
    logic [PW-1:0]  r_rd_ptr, n_rd_ptr;
    logic [CW-1:0]  r_count, n_count;

    assign o_full  = (r_count == CW'(QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_item  = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == PW'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == PW'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (!i_push && i_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

`ifndef SYNTHESIS
    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_push && o_full && !i_pop))
        else $error("push into full queue");
    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> o_valid)
        else $error("pop from empty queue");
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(QUEUE_DEPTH))
        else $error("queue count out of range");
`endif
endmodule

// File: sv/rclp_back.sv
module rclp_back #(
    parameter int MAX_KEY_FIELDS = 8,
    parameter int FIELD_BYTES    = 256
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    input  rclp_pkg::t_item i_item,
    output logic            o_pop,
    rclp_out_if.source      o_res
);
    import rclp_pkg::*;

    localparam int KW = $clog2(MAX_KEY_FIELDS + 1);
    localparam int OW = $clog2(FIELD_BYTES);

    logic [1:0]           r_line_class, n_line_class;
    logic [2:0]           r_content, n_content;
    logic [CMD_COUNT-1:0] r_mask, n_mask;
    logic [3:0]           r_name_len, n_name_len;
    logic                 r_too_long, n_too_long;
    logic [4:0]           r_cmd, n_cmd;
    logic [31:0]          r_count, n_count;
    logic [31:0]          r_acc, n_acc;
    logic                 r_digit_seen, n_digit_seen;
    logic                 r_minus, n_minus;
    logic [1:0]           r_phase, n_phase;
    logic [KW-1:0]        r_keys, n_keys;
    logic [OW-1:0]        r_offset, n_offset;
    logic                 r_out_valid, n_out_valid;
    t_result              r_out, n_out;

    logic                 take;
    logic [4:0]           match_code;
    logic [CMD_COUNT-1:0] hits;
    logic                 multi_cmd;
    logic                 keys_room;
    logic [4:0]           fin_cmd;
    logic [KW-1:0]        fin_keys;
    logic [31:0]          fin_count;
    logic                 new_content;
    logic                 content_byte;
    logic [2:0]           cnt_eff;
    logic                 slot_ok;
    logic [1:0]           slot_sel;
    logic [35:0]          acc_prod;
    logic [OW+7:0]        off_ext;
    logic [KW+2:0]        kn_ext;
    logic [KW+31:0]       keys_ext;

    assign take  = i_valid && (!r_out_valid || o_res.ready);
    assign o_pop = take;

    // first-line match: candidates narrow one byte at a time
    always_comb begin
        for (int i = 0; i < CMD_COUNT; i++) begin
            hits[i] = (i_item.data == name_char(i, r_name_len));
        end
        match_code = OP_UNKNOWN;
        for (int i = CMD_COUNT - 1; i >= 0; i--) begin
            if (!r_too_long && r_mask[i] && r_name_len == CMD_LEN[i]) begin
                match_code = 5'(i + 1);
            end
        end
    end

    assign multi_cmd = (r_cmd == OP_DEL) || (r_cmd == OP_EXISTS);
    assign keys_room = (r_keys < KW'(MAX_KEY_FIELDS));

    // state as it stands once the open line is finished
    always_comb begin
        fin_cmd   = r_cmd;
        fin_keys  = r_keys;
        fin_count = r_count;
        if (r_line_class == LC_CONTENT) begin
            if (r_content == 3'd1) begin
                fin_cmd = match_code;
            end else if (multi_cmd && keys_room) begin
                fin_keys = r_keys + 1'b1;
            end
        end else if (r_line_class == LC_STAR && r_digit_seen) begin
            if (r_minus) begin
                fin_count = 32'd0 - r_acc;
            end else begin
                fin_count = r_acc[31] ? POS_MAX : r_acc;
            end
        end
    end

    assign new_content  = (r_line_class == LC_IDLE) && !i_item.is_star && !i_item.is_dollar;
    assign content_byte = new_content || (r_line_class == LC_CONTENT);
    assign cnt_eff      = (r_line_class == LC_IDLE) ?
                          ((r_content == CNT_SAT) ? r_content : r_content + 1'b1) : r_content;

    always_comb begin
        slot_ok  = 1'b0;
        slot_sel = SLOT_ARG;
        unique case (r_cmd) inside
            OP_PING: begin
                slot_ok  = (cnt_eff == 3'd2);
                slot_sel = SLOT_ARG;
            end
            OP_GET, OP_PERSIST, OP_TTL, OP_PTTL, OP_KEYS, OP_INCR, OP_DECR: begin
                slot_ok  = (cnt_eff == 3'd2);
                slot_sel = SLOT_KEY;
            end
            OP_SET, OP_APPEND, OP_EXPIRE, OP_PEXPIRE, OP_RENAME, OP_COPY,
            OP_INCRBY, OP_DECRBY: begin
                slot_ok  = (cnt_eff == 3'd2) || (cnt_eff == 3'd3);
                slot_sel = (cnt_eff == 3'd2) ? SLOT_KEY : SLOT_VALUE;
            end
            OP_DEL, OP_EXISTS: begin
                slot_ok  = keys_room;
                slot_sel = SLOT_MULTI;
            end
            default: begin
                slot_ok  = 1'b0;
                slot_sel = SLOT_ARG;
            end
        endcase
    end

    // times ten plus digit as shift and add
    assign acc_prod = {1'b0, r_acc, 3'b000} + {3'b000, r_acc, 1'b0} + {32'd0, i_item.data[3:0]};

    assign off_ext  = {8'd0, r_offset};
    assign kn_ext   = {3'd0, r_keys};
    assign keys_ext = {32'd0, fin_keys};

    always_comb begin
        n_line_class = r_line_class;
        n_content    = r_content;
        n_mask       = r_mask;
        n_name_len   = r_name_len;
        n_too_long   = r_too_long;
        n_cmd        = r_cmd;
        n_count      = r_count;
        n_acc        = r_acc;
        n_digit_seen = r_digit_seen;
        n_minus      = r_minus;
        n_phase      = r_phase;
        n_keys       = r_keys;
        n_offset     = r_offset;
        n_out_valid  = r_out_valid && !o_res.ready;
        n_out        = r_out;

        if (take) begin
            if (i_item.kind == KIND_END || i_item.is_eol) begin
                n_line_class = LC_IDLE;
                n_offset     = '0;
                n_name_len   = '0;
                n_too_long   = 1'b0;
                n_mask       = '1;
                n_acc        = '0;
                n_digit_seen = 1'b0;
                n_minus      = 1'b0;
                n_phase      = PH_BLANK;
                n_cmd        = fin_cmd;
                n_keys       = fin_keys;
                n_count      = fin_count;
                if (i_item.kind == KIND_END) begin
                    n_out_valid           = 1'b1;
                    n_out                 = '0;
                    n_out.result_kind     = RK_SUMMARY;
                    n_out.command         = fin_cmd;
                    n_out.key_count       = (fin_cmd == OP_DEL || fin_cmd == OP_EXISTS) ?
                                            keys_ext[31:0] : fin_count;
                    n_content             = '0;
                    n_cmd                 = OP_NONE;
                    n_count               = '0;
                    n_keys                = '0;
                end
            end else begin
                if (r_line_class == LC_IDLE) begin
                    if (i_item.is_star) begin
                        n_line_class = LC_STAR;
                    end else if (i_item.is_dollar) begin
                        n_line_class = LC_DOLLAR;
                    end else begin
                        n_line_class = LC_CONTENT;
                        n_content    = cnt_eff;
                    end
                end else if (r_line_class == LC_STAR) begin
                    if (r_phase == PH_BLANK && i_item.is_blank) begin
                        n_phase = PH_BLANK;
                    end else if (r_phase == PH_BLANK && i_item.is_sign) begin
                        n_minus = i_item.is_minus;
                        n_phase = PH_SIGN;
                    end else if (r_phase != PH_STOP && i_item.is_digit) begin
                        n_acc        = (acc_prod > {4'd0, MAG_CAP}) ? MAG_CAP : acc_prod[31:0];
                        n_digit_seen = 1'b1;
                        n_phase      = PH_DIGITS;
                    end else begin
                        n_phase = PH_STOP;
                    end
                end

                if (content_byte) begin
                    if (cnt_eff == 3'd1) begin
                        if (r_name_len < 4'(NAME_MAX)) begin
                            n_name_len = r_name_len + 1'b1;
                            n_mask     = r_mask & hits;
                        end else begin
                            n_too_long = 1'b1;
                        end
                    end else if (slot_ok && r_offset < OW'(FIELD_BYTES - 1)) begin
                        n_out_valid       = 1'b1;
                        n_out.result_kind = RK_ARG;
                        n_out.command     = r_cmd;
                        n_out.slot        = slot_sel;
                        n_out.key_number  = (slot_sel == SLOT_MULTI) ? kn_ext[2:0] : 3'd0;
                        n_out.offset      = off_ext[7:0];
                        n_out.arg_byte    = i_item.data;
                        n_out.key_count   = '0;
                        n_offset          = r_offset + 1'b1;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_line_class <= LC_IDLE;
            r_content    <= '0;
            r_mask       <= '1;
            r_name_len   <= '0;
            r_too_long   <= 1'b0;
            r_cmd        <= OP_NONE;
            r_count      <= '0;
            r_acc        <= '0;
            r_digit_seen <= 1'b0;
            r_minus      <= 1'b0;
            r_phase      <= PH_BLANK;
            r_keys       <= '0;
            r_offset     <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            r_line_class <= n_line_class;
            r_content    <= n_content;
            r_mask       <= n_mask;
            r_name_len   <= n_name_len;
            r_too_long   <= n_too_long;
            r_cmd        <= n_cmd;
            r_count      <= n_count;
            r_acc        <= n_acc;
            r_digit_seen <= n_digit_seen;
            r_minus      <= n_minus;
            r_phase      <= n_phase;
            r_keys       <= n_keys;
            r_offset     <= n_offset;
            r_out_valid  <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

    assign o_res.valid       = r_out_valid;
    assign o_res.result_kind = r_out.result_kind;
    assign o_res.command     = r_out.command;
    assign o_res.slot        = r_out.slot;
    assign o_res.key_number  = r_out.key_number;
    assign o_res.offset      = r_out.offset;
    assign o_res.arg_byte    = r_out.arg_byte;
    assign o_res.key_count   = r_out.key_count;

`ifndef SYNTHESIS
    a_arg_needs_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.result_kind == RK_ARG) |->
        (r_out.command != OP_NONE && r_out.command != OP_UNKNOWN &&
         r_out.command != OP_RANDOMKEY && r_out.command != OP_HELPER))
        else $error("argument byte for a command that takes none");
    a_key_number_multi: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.result_kind == RK_ARG && r_out.slot != SLOT_MULTI) |->
        (r_out.key_number == 3'd0))
        else $error("key number outside multi-key slot");
    a_end_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (take && i_item.kind == KIND_END) |=>
        (r_line_class == LC_IDLE && r_cmd == OP_NONE && r_keys == '0 && r_content == '0))
        else $error("message state not cleared after end");
    a_offset_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_offset <= OW'(FIELD_BYTES - 1))
        else $error("line offset past field size");
`endif
endmodule

// File: sv/resp_command_line_parser_core.sv
// Parses one array-framed command message per transaction stream: message bytes
// followed by an end marker. It takes one input transaction every clock cycle
// while the queue is not full, and gives at most one result per input; an
// accepted input is written into the queue, and the execute stage registers
// its result in the output register once that register is free to take it.
// The execute stage does all per-byte state update together: star-line
// times-ten accumulate, narrowing of the command-name candidates, and slot
// and offset selection. A stalled output backs up into the queue, and the
// input drops ready once both queue entries are held.
module resp_command_line_parser_core #(
    parameter int MAX_KEY_FIELDS = 8,
    parameter int FIELD_BYTES    = 256
) (
    input logic         i_clk,
    input logic         i_rst_n,
    rclp_in_if.sink     i_cmd,
    rclp_out_if.source  o_res
);
    import rclp_pkg::*;

    logic  push;
    logic  full;
    logic  q_valid;
    logic  pop;
    t_item push_item;
    t_item q_item;

    rclp_front u_front (
        .i_cmd  (i_cmd),
        .i_full (full),
        .o_push (push),
        .o_item (push_item)
    );

    rclp_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (push_item),
        .o_full  (full),
        .o_valid (q_valid),
        .o_item  (q_item),
        .i_pop   (pop)
    );

    rclp_back #(
        .MAX_KEY_FIELDS (MAX_KEY_FIELDS),
        .FIELD_BYTES    (FIELD_BYTES)
    ) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (q_valid),
        .i_item  (q_item),
        .o_pop   (pop),
        .o_res   (o_res)
    );
endmodule

// File: tb/sv/resp_command_line_parser_core_tb.sv
module resp_command_line_parser_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import rclp_pkg::*;

    localparam int KEY_FIELDS   = 8;
    localparam int FIELD_LEN    = 256;
    localparam int IDLE_PCT     = 35;
    localparam int ITEM_TARGET  = 400;
    localparam int DRAIN_CYCLES = 8;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int LONG_MSG     = 0;

    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_STAR   = "*";
    localparam logic [7:0] CH_DOLLAR = "$";
    localparam logic [7:0] CH_PLUS   = "+";
    localparam logic [7:0] CH_MINUS  = "-";
    localparam logic [7:0] CH_SPACE  = " ";
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_VT     = 8'h0B;
    localparam logic [7:0] CH_FF     = 8'h0C;

    localparam logic [7:0] BLANKS [4] = '{CH_SPACE, CH_TAB, CH_VT, CH_FF};
    localparam logic [7:0] NOISE  [4] = '{CH_CR, CH_LF, CH_STAR, CH_DOLLAR};

    typedef struct {
        logic       kind;
        logic [7:0] data;
    } t_txn;

    typedef struct {
        logic       kind;
        logic [7:0] data;
        bit         typed;
        t_result    want;
    } t_row;

    logic i_clk = 1'b0;
    logic i_rst_n;

    rclp_in_if  cmd_if ();
    rclp_out_if res_if ();

    resp_command_line_parser_core #(
        .MAX_KEY_FIELDS(KEY_FIELDS),
        .FIELD_BYTES(FIELD_LEN)
    ) DUT (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_cmd(cmd_if),
        .o_res(res_if)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    string cmd_names [CMD_COUNT] = '{
        "PING", "SET", "GET", "DEL", "EXISTS", "APPEND", "RANDOMKEY", "EXPIRE",
        "PEXPIRE", "PERSIST", "TTL", "KEYS", "PTTL", "RENAME", "COPY", "INCR",
        "DECR", "INCRBY", "DECRBY", "HELPER"
    };

    // parser state mirrored by the predictor
    logic [1:0]      line_cls;
    int              content_cnt;
    logic [7:0]      name_buf [NAME_MAX];
    int              name_len;
    bit              name_long;
    logic [4:0]      cmd_code;
    logic [31:0]     count_val;
    longint unsigned count_mag;
    bit              has_digit;
    bit              is_neg;
    logic [1:0]      star_ph;
    int              keys_cnt;
    int              field_pos;

    t_result pending_results [$];
    t_txn    msg [$];

    bit gaps_on  = 1'b1;
    bit stall_on = 1'b1;
    int txn_count   = 0;
    int msg_count   = 0;
    int fail_count  = 0;
    int summaries   = 0;
    int arg_bytes   = 0;
    int cycle_count = 0;

    function automatic bit is_multi(input logic [4:0] code);
        return code == OP_DEL || code == OP_EXISTS;
    endfunction

    function automatic void clear_line_state();
        line_cls  = LC_IDLE;
        field_pos = 0;
        name_len  = 0;
        name_long = 1'b0;
        foreach (name_buf[i]) name_buf[i] = 8'h00;
        count_mag = 0;
        has_digit = 1'b0;
        is_neg    = 1'b0;
        star_ph   = PH_BLANK;
    endfunction

    function automatic void reset_parse_state();
        clear_line_state();
        content_cnt = 0;
        cmd_code    = OP_NONE;
        count_val   = '0;
        keys_cnt    = 0;
    endfunction

    function automatic logic [4:0] lookup_command();
        bit same;
        if (name_long) return OP_UNKNOWN;
        for (int i = 0; i < CMD_COUNT; i++) begin
            if (cmd_names[i].len() == name_len) begin
                same = 1'b1;
                for (int j = 0; j < name_len; j++)
                    if (cmd_names[i][j] != name_buf[j]) same = 1'b0;
                if (same) return OP_PING + 5'(i);
            end
        end
        return OP_UNKNOWN;
    endfunction

    function automatic void end_line();
        longint unsigned mag;
        mag = count_mag;
        if (line_cls == LC_STAR && has_digit) begin
            if (is_neg) begin
                if (mag > 64'h8000_0000) mag = 64'h8000_0000;
                count_val = 32'(64'h0 - mag);
            end else begin
                if (mag > 64'h7FFF_FFFF) mag = 64'h7FFF_FFFF;
                count_val = 32'(mag);
            end
        end else if (line_cls == LC_CONTENT) begin
            if (content_cnt == 1)
                cmd_code = lookup_command();
            else if (is_multi(cmd_code) && keys_cnt < KEY_FIELDS)
                keys_cnt++;
        end
        clear_line_state();
    endfunction

    function automatic void star_char(input logic [7:0] b);
        bit digit;
        digit = (b >= "0" && b <= "9");
        if (star_ph == PH_BLANK) begin
            if (b == CH_SPACE || b == CH_TAB || b == CH_VT || b == CH_FF) return;
            if (b == CH_PLUS || b == CH_MINUS) begin
                if (b == CH_MINUS) is_neg = 1'b1;
                star_ph = PH_SIGN;
                return;
            end
        end
        if (star_ph != PH_STOP && digit) begin
            count_mag = count_mag * 10 + 64'(b - "0");
            if (count_mag > 64'h8000_0000) count_mag = 64'h8000_0000;
            has_digit = 1'b1;
            star_ph   = PH_DIGITS;
            return;
        end
        star_ph = PH_STOP;
    endfunction

    // field slot of the current content line, -1 when its bytes are dropped
    function automatic int arg_slot();
        case (cmd_code) inside
            OP_PING:
                if (content_cnt == 2) return int'(SLOT_ARG);
            OP_GET, OP_PERSIST, OP_TTL, OP_PTTL, OP_KEYS, OP_INCR, OP_DECR:
                if (content_cnt == 2) return int'(SLOT_KEY);
            OP_SET, OP_APPEND, OP_EXPIRE, OP_PEXPIRE, OP_RENAME, OP_COPY,
            OP_INCRBY, OP_DECRBY: begin
                if (content_cnt == 2) return int'(SLOT_KEY);
                if (content_cnt == 3) return int'(SLOT_VALUE);
            end
            OP_DEL, OP_EXISTS:
                if (keys_cnt < KEY_FIELDS) return int'(SLOT_MULTI);
            default: ;
        endcase
        return -1;
    endfunction

    function automatic bit predict_parse(input logic k, input logic [7:0] b,
                                         output t_result r);
        int slot;
        r = '0;
        if (k == KIND_END) begin
            end_line();
            r.result_kind = RK_SUMMARY;
            r.command     = cmd_code;
            r.key_count   = is_multi(cmd_code) ? 32'(keys_cnt) : count_val;
            reset_parse_state();
            return 1'b1;
        end
        if (b == CH_CR || b == CH_LF) begin
            if (line_cls != LC_IDLE)
                end_line();
            return 1'b0;
        end
        if (line_cls == LC_IDLE) begin
            if (b == CH_STAR) begin
                line_cls = LC_STAR;
                return 1'b0;
            end
            if (b == CH_DOLLAR) begin
                line_cls = LC_DOLLAR;
                return 1'b0;
            end
            line_cls = LC_CONTENT;
            if (content_cnt < 255) content_cnt++;
        end
        if (line_cls == LC_STAR) begin
            star_char(b);
            return 1'b0;
        end
        if (line_cls == LC_DOLLAR)
            return 1'b0;
        if (content_cnt == 1) begin
            if (name_len < NAME_MAX) begin
                name_buf[name_len] = b;
                name_len++;
            end else begin
                name_long = 1'b1;
            end
            return 1'b0;
        end
        slot = arg_slot();
        if (slot < 0 || field_pos >= FIELD_LEN - 1)
            return 1'b0;
        r.result_kind = RK_ARG;
        r.command     = cmd_code;
        r.slot        = 2'(slot);
        r.key_number  = (slot == int'(SLOT_MULTI)) ? 3'(keys_cnt) : 3'd0;
        r.offset      = 8'(field_pos);
        r.arg_byte    = b;
        field_pos++;
        return 1'b1;
    endfunction

    function automatic t_result summary_of(input logic [4:0] cmd, input logic [31:0] cnt);
        t_result r;
        r             = '0;
        r.result_kind = RK_SUMMARY;
        r.command     = cmd;
        r.key_count   = cnt;
        return r;
    endfunction

    function automatic string fmt_result(input t_result r);
        return $sformatf("kind=%0d cmd=%0d slot=%0d key=%0d off=%0d byte=%02h cnt=%0d",
                         r.result_kind, r.command, r.slot, r.key_number, r.offset,
                         r.arg_byte, $signed(r.key_count));
    endfunction

    function automatic void report_mismatch(input string what, input t_result want,
                                            input t_result got);
        if (fail_count < 10)
            $display("[%0t] %s: expected %s, got %s",
                     $time, what, fmt_result(want), fmt_result(got));
        fail_count++;
    endfunction

    function automatic void check_result();
        t_result got;
        t_result want;
        got.result_kind = res_if.result_kind;
        got.command     = res_if.command;
        got.slot        = res_if.slot;
        got.key_number  = res_if.key_number;
        got.offset      = res_if.offset;
        got.arg_byte    = res_if.arg_byte;
        got.key_count   = res_if.key_count;
        if (pending_results.size() == 0) begin
            report_mismatch("unexpected result", '0, got);
            return;
        end
        want = pending_results.pop_front();
        if (got.result_kind !== want.result_kind || got.command !== want.command ||
            got.slot !== want.slot || got.key_number !== want.key_number ||
            got.offset !== want.offset || got.arg_byte !== want.arg_byte ||
            got.key_count !== want.key_count)
            report_mismatch("result mismatch", want, got);
        if (got.result_kind == RK_SUMMARY)
            summaries++;
        else
            arg_bytes++;
    endfunction

    always @(posedge i_clk) begin
        res_if.ready <= !stall_on || ($urandom_range(99) >= IDLE_PCT);
        if (i_rst_n && res_if.valid && res_if.ready) check_result();
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    task automatic send_txn(input logic k, input logic [7:0] b, input bit typed,
                            input t_result want);
        t_result got;
        bit      has;
        if (gaps_on)
            while ($urandom_range(99) < IDLE_PCT) begin
                cmd_if.valid <= 1'b0;
                @(posedge i_clk);
            end
        cmd_if.valid     <= 1'b1;
        cmd_if.kind      <= k;
        cmd_if.data_byte <= b;
        do @(posedge i_clk); while (!cmd_if.ready);
        has = predict_parse(k, b, got);
        if (typed) begin
            has = 1'b1;
            got = want;
        end
        if (has) pending_results.push_back(got);
        txn_count++;
    endtask

    // hold off the sender until the block has delivered everything
    task automatic wait_drained();
        cmd_if.valid <= 1'b0;
        do @(posedge i_clk); while (pending_results.size() != 0);
    endtask

    function automatic void add_byte(input logic [7:0] b);
        msg.push_back('{KIND_BYTE, b});
    endfunction

    function automatic void add_text(input string s);
        foreach (s[i]) add_byte(s[i]);
    endfunction

    function automatic void add_eol();
        case ($urandom_range(9))
            0: add_byte(CH_LF);
            1: add_byte(CH_CR);
            2: add_text("\r\n\r\n");
            default: add_text("\r\n");
        endcase
    endfunction

    // any byte but a line break; a line start mostly avoids star and dollar
    function automatic logic [7:0] text_byte(input bit first);
        logic [7:0] b;
        do b = 8'($urandom_range(255));
        while (b == CH_CR || b == CH_LF ||
               (first && (b == CH_STAR || b == CH_DOLLAR) && $urandom_range(9) != 0));
        return b;
    endfunction

    function automatic void add_field(input int len);
        for (int i = 0; i < len; i++) add_byte(text_byte(i == 0));
    endfunction

    function automatic void add_dollar_line();
        if ($urandom_range(1)) begin
            add_byte(CH_DOLLAR);
            add_byte("0" + 8'($urandom_range(9)));
            add_eol();
        end
    endfunction

    function automatic void add_star_line();
        string limit_counts [6] = '{"2147483647", "2147483648", "-2147483648",
                                    "-2147483649", "-0", "+0"};
        add_byte(CH_STAR);
        if ($urandom_range(9) == 0) begin
            add_text(limit_counts[$urandom_range(5)]);
        end else begin
            repeat ($urandom_range(2)) add_byte(BLANKS[$urandom_range(3)]);
            case ($urandom_range(3))
                0: add_byte(CH_MINUS);
                1: add_byte(CH_PLUS);
                default: ;
            endcase
            repeat ($urandom_range(12)) add_byte("0" + 8'($urandom_range(9)));
            if ($urandom_range(4) == 0) add_byte(text_byte(1'b0));
        end
        add_eol();
    endfunction

    function automatic logic [4:0] add_name_line();
        logic [7:0] nb [$];
        logic [4:0] code;
        string      nm;
        if ($urandom_range(9) < 3)
            code = $urandom_range(1) ? OP_DEL : OP_EXISTS;
        else
            code = OP_PING + 5'($urandom_range(CMD_COUNT - 1));
        nm = cmd_names[code - OP_PING];
        foreach (nm[i]) nb.push_back(nm[i]);
        case ($urandom_range(19))
            0, 1: nb[$urandom_range(nb.size() - 1)] = text_byte(1'b0);
            2: repeat (NAME_MAX + 1 - nb.size() + $urandom_range(3))
                   nb.push_back(text_byte(1'b0));
            3: void'(nb.pop_back());
            default: ;
        endcase
        foreach (nb[i]) add_byte(nb[i]);
        add_eol();
        return code;
    endfunction

    function automatic void build_message();
        logic [4:0] code;
        int         n_args;
        msg.delete();
        if ($urandom_range(99) < 8) begin
            repeat ($urandom_range(1, 30)) begin
                if ($urandom_range(3) == 0)
                    add_byte(NOISE[$urandom_range(3)]);
                else
                    add_byte(8'($urandom_range(255)));
            end
        end else begin
            if ($urandom_range(9) < 7) add_star_line();
            add_dollar_line();
            code = add_name_line();
            // a late star line reloads the count after the name
            if ($urandom_range(9) == 0) add_star_line();
            n_args = is_multi(code) ? $urandom_range(11) : $urandom_range(4);
            for (int a = 0; a < n_args; a++) begin
                add_dollar_line();
                add_field($urandom_range(1, 12));
                if (a < n_args - 1 || $urandom_range(9) != 0) add_eol();
            end
        end
        msg.push_back('{KIND_END, 8'($urandom_range(255))});
    endfunction

    // key line longer than the field so its tail is cut off
    function automatic void build_long_message();
        msg.delete();
        add_text("SET\r\n");
        add_field(FIELD_LEN + 4);
        add_eol();
        add_field(3);
        msg.push_back('{KIND_END, 8'h00});
    endfunction

    initial begin
        t_row script [23];
        bit   quiet;

        cmd_if.valid     <= 1'b0;
        cmd_if.kind      <= KIND_BYTE;
        cmd_if.data_byte <= 8'h00;
        i_rst_n          <= 1'b0;
        reset_parse_state();

        script = '{
            '{KIND_END,  8'h00,     1'b1, summary_of(OP_NONE, 32'd0)},
            '{KIND_BYTE, 8'h00,     1'b0, '0},
            '{KIND_BYTE, 8'hFF,     1'b0, '0},
            '{KIND_BYTE, CH_CR,     1'b0, '0},
            '{KIND_BYTE, CH_LF,     1'b0, '0},
            '{KIND_END,  8'h00,     1'b1, summary_of(OP_UNKNOWN, 32'd0)},
            '{KIND_BYTE, CH_STAR,   1'b0, '0},
            '{KIND_BYTE, CH_MINUS,  1'b0, '0},
            '{KIND_BYTE, "9", 1'b0, '0}, '{KIND_BYTE, "9", 1'b0, '0},
            '{KIND_BYTE, "9", 1'b0, '0}, '{KIND_BYTE, "9", 1'b0, '0},
            '{KIND_BYTE, "9", 1'b0, '0}, '{KIND_BYTE, "9", 1'b0, '0},
            '{KIND_BYTE, "9", 1'b0, '0}, '{KIND_BYTE, "9", 1'b0, '0},
            '{KIND_BYTE, "9", 1'b0, '0}, '{KIND_BYTE, "9", 1'b0, '0},
            '{KIND_BYTE, CH_LF,     1'b0, '0},
            '{KIND_END,  8'h00,     1'b1, summary_of(OP_NONE, 32'h8000_0000)},
            '{KIND_BYTE, CH_DOLLAR, 1'b0, '0},
            '{KIND_BYTE, 8'hFF,     1'b0, '0},
            '{KIND_END,  8'hFF,     1'b1, summary_of(OP_NONE, 32'd0)}
        };

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (script[i])
            send_txn(script[i].kind, script[i].data, script[i].typed, script[i].want);
        wait_drained();

        while (txn_count < ITEM_TARGET) begin
            quiet    = (msg_count > LONG_MSG && msg_count <= LONG_MSG + 3);
            gaps_on  = !quiet;
            stall_on = !quiet;
            if (msg_count == LONG_MSG)
                build_long_message();
            else
                build_message();
            if (msg_count == LONG_MSG || $urandom_range(9) == 0) wait_drained();
            foreach (msg[i]) send_txn(msg[i].kind, msg[i].data, 1'b0, '0);
            msg_count++;
        end

        cmd_if.valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("parsed %0d messages in %0d input transactions",
                 msg_count, txn_count);
        $display("checked %0d argument bytes and %0d message summaries, %0d mismatches",
                 arg_bytes, summaries, fail_count);
        if (fail_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

// File: resp_command_line_parser_core.f
sv/rclp_pkg.sv
sv/rclp_in_if.sv
sv/rclp_out_if.sv
sv/rclp_front.sv
sv/rclp_queue.sv
sv/rclp_back.sv
sv/resp_command_line_parser_core.sv
tb/sv/resp_command_line_parser_core_tb.sv
